[rtl/beep_pattern_sequencer_defines.svh]
// assertion helpers for the sequencer rtl
`ifndef BEEP_PATTERN_SEQUENCER_DEFINES_SVH
`define BEEP_PATTERN_SEQUENCER_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define BPS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("beep sequencer check failed");

// next-cycle implication, disabled while reset is high
`define BPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("beep sequencer check failed");

`endif

[rtl/bps_pkg.sv]
package bps_pkg;

   // command codes
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_STOP  = 2'd2;

   // note codes
   localparam logic [2:0] NOTE_PAUSE = 3'd0;
   localparam logic [2:0] NOTE_DO    = 3'd1;
   localparam logic [2:0] NOTE_MI    = 3'd2;
   localparam logic [2:0] NOTE_SOL   = 3'd3;
   localparam logic [2:0] NOTE_LA    = 3'd4;
   localparam logic [2:0] NOTE_HDO   = 3'd5;

   // rom geometry and limits
   localparam int ROM_PATTERNS = 9;
   localparam int ROM_SLOTS    = 8;
   localparam logic [3:0] PATTERN_COUNT = 4'd9;
   localparam logic [2:0] MAX_NOTES     = 3'd7;

   // master volume
   localparam logic [6:0] VOL_RESET = 7'd100;
   localparam logic [6:0] VOL_MAX   = 7'd100;

   typedef logic [3:0]  pattern_type;
   typedef logic [2:0]  slot_type;
   typedef logic [2:0]  note_type;
   typedef logic [7:0]  dur_type;
   typedef logic [14:0] vol_mul_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [3:0]  beep_type;
      logic [15:0] elapsed_ms;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } req_beat_type;

   localparam note_type ROM_CODE [ROM_PATTERNS][ROM_SLOTS] = '{
      '{NOTE_SOL, NOTE_PAUSE, NOTE_PAUSE, NOTE_PAUSE, NOTE_PAUSE, NOTE_PAUSE, NOTE_PAUSE,
        NOTE_PAUSE},
      '{NOTE_MI, NOTE_PAUSE, NOTE_MI, NOTE_PAUSE, NOTE_PAUSE, NOTE_PAUSE, NOTE_PAUSE,
        NOTE_PAUSE},
      '{NOTE_DO, NOTE_PAUSE, NOTE_MI, NOTE_PAUSE, NOTE_SOL, NOTE_PAUSE, NOTE_PAUSE,
        NOTE_PAUSE},
      '{NOTE_DO, NOTE_PAUSE, NOTE_MI, NOTE_PAUSE, NOTE_SOL, NOTE_PAUSE, NOTE_HDO,
        NOTE_PAUSE},
      '{NOTE_SOL, NOTE_PAUSE, NOTE_MI, NOTE_PAUSE, NOTE_DO, NOTE_PAUSE, NOTE_PAUSE,
        NOTE_PAUSE},
      '{NOTE_LA, NOTE_PAUSE, NOTE_LA, NOTE_PAUSE, NOTE_LA, NOTE_PAUSE, NOTE_LA,
        NOTE_PAUSE},
      '{NOTE_DO, NOTE_PAUSE, NOTE_SOL, NOTE_PAUSE, NOTE_HDO, NOTE_PAUSE, NOTE_PAUSE,
        NOTE_PAUSE},
      '{NOTE_HDO, NOTE_PAUSE, NOTE_PAUSE, NOTE_PAUSE, NOTE_PAUSE, NOTE_PAUSE, NOTE_PAUSE,
        NOTE_PAUSE},
      '{NOTE_SOL, NOTE_PAUSE, NOTE_HDO, NOTE_PAUSE, NOTE_PAUSE, NOTE_PAUSE, NOTE_PAUSE,
        NOTE_PAUSE}
   };

   localparam dur_type ROM_DUR [ROM_PATTERNS][ROM_SLOTS] = '{
      '{8'd60,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0,  8'd0,   8'd0},
      '{8'd25,  8'd50,  8'd25,  8'd0,   8'd0,   8'd0,  8'd0,   8'd0},
      '{8'd25,  8'd50,  8'd30,  8'd50,  8'd35,  8'd0,  8'd0,   8'd0},
      '{8'd80,  8'd30,  8'd80,  8'd30,  8'd80,  8'd30, 8'd120, 8'd0},
      '{8'd100, 8'd50,  8'd100, 8'd50,  8'd150, 8'd0,  8'd0,   8'd0},
      '{8'd50,  8'd30,  8'd50,  8'd100, 8'd50,  8'd30, 8'd50,  8'd0},
      '{8'd100, 8'd50,  8'd100, 8'd50,  8'd150, 8'd0,  8'd0,   8'd0},
      '{8'd30,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0,  8'd0,   8'd0},
      '{8'd60,  8'd40,  8'd80,  8'd0,   8'd0,   8'd0,  8'd0,   8'd0}
   };

   localparam slot_type ROM_COUNT [ROM_PATTERNS] = '{
      3'd1, 3'd3, 3'd5, 3'd7, 3'd5, 3'd7, 3'd5, 3'd1, 3'd3
   };

   // pattern volume v scaled to ceil(v * 2^16 / 100): (master * k) >> 16 gives
   // floor(v * master / 100) exactly for master up to 100
   localparam vol_mul_type ROM_VOL_MUL [ROM_PATTERNS] = '{
      15'd13108, 15'd16384, 15'd19661, 15'd13108, 15'd16384,
      15'd19661, 15'd13108, 15'd9831,  15'd13108
   };

   function automatic note_type rom_code(pattern_type p, slot_type i);
      rom_code = NOTE_PAUSE;
      if (p < PATTERN_COUNT) rom_code = ROM_CODE[p][i];
   endfunction

   function automatic dur_type rom_dur(pattern_type p, slot_type i);
      rom_dur = 8'd0;
      if (p < PATTERN_COUNT) rom_dur = ROM_DUR[p][i];
   endfunction

   // note count clipped to the longest supported pattern
   function automatic slot_type rom_count(pattern_type p);
      rom_count = 3'd0;
      if (p < PATTERN_COUNT) rom_count = ROM_COUNT[p];
      if (rom_count > MAX_NOTES) rom_count = MAX_NOTES;
   endfunction

   function automatic vol_mul_type rom_vol_mul(pattern_type p);
      rom_vol_mul = 15'd0;
      if (p < PATTERN_COUNT) rom_vol_mul = ROM_VOL_MUL[p];
   endfunction

endpackage

[rtl/bps_csr.sv]
module bps_csr (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [6:0] csr_wr_data,
   output logic [6:0] master_volume
);

   logic [6:0] master_volume_ff;
   logic [6:0] master_volume_in;

   // clamp writes to full scale
   always_comb begin
      master_volume_in = master_volume_ff;
      if (csr_wr_en) begin
         master_volume_in = (csr_wr_data > bps_pkg::VOL_MAX) ? bps_pkg::VOL_MAX : csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         master_volume_ff <= bps_pkg::VOL_RESET;
      end else begin
         master_volume_ff <= master_volume_in;
      end
   end

   assign master_volume = master_volume_ff;

endmodule

[rtl/bps_req_stage.sv]
module bps_req_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_command,
   input  logic [3:0]           req_beep_type,
   input  logic [15:0]          req_elapsed_ms,
   input  logic                 take,
   output bps_pkg::req_beat_type beat
);

   logic              valid_ff;
   logic              valid_in;
   bps_pkg::item_type item_ff;
   bps_pkg::item_type item_in;
   logic              load;

   // hold a beat until the player takes it
   assign req_stall = valid_ff && !take;
   assign load      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in           = 1'b1;
         item_in.command    = req_command;
         item_in.beep_type  = req_beep_type;
         item_in.elapsed_ms = req_elapsed_ms;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload register
   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign beat.valid = valid_ff;
   assign beat.item  = item_ff;

endmodule

[rtl/bps_player.sv]
`include "beep_pattern_sequencer_defines.svh"

module bps_player #(
   parameter int TIME_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [6:0]            master_volume,
   input  bps_pkg::req_beat_type beat,
   output logic                  take,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [2:0]            rsp_tone_note,
   output logic [6:0]            rsp_duty_percent,
   output logic                  rsp_playing
);

   localparam int SUM_W = ((TIME_BITS > 16) ? TIME_BITS : 16) + 1;
   localparam logic [SUM_W-1:0] TMAX = SUM_W'({TIME_BITS{1'b1}});

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 active_ff, active_in;
   bps_pkg::pattern_type pattern_ff, pattern_in;
   bps_pkg::slot_type    pos_ff, pos_in;
   logic [TIME_BITS-1:0] time_ff, time_in;
   bps_pkg::note_type    note_ff, note_in;
   logic [6:0]           duty_ff, duty_in;

   logic                 out_free;
   logic                 is_start;
   logic                 start_ok;
   bps_pkg::slot_type    pos_next;
   bps_pkg::pattern_type sel_pat;
   bps_pkg::slot_type    sel_pos;
   bps_pkg::note_type    lk_code;
   logic [21:0]          scaled;
   logic [6:0]           lk_duty;
   logic [SUM_W-1:0]     time_sum;
   logic [TIME_BITS-1:0] tick_time;
   logic [TIME_BITS-1:0] cur_dur;

   // result register frees when empty or being read
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign take     = beat.valid && out_free;

   assign is_start = (beat.item.command == bps_pkg::CMD_START);
   assign start_ok = (beat.item.beep_type < bps_pkg::PATTERN_COUNT);
   assign pos_next = pos_ff + 3'd1;

   // one shared note lookup and volume scale: first note on start, next note on advance
   assign sel_pat = is_start ? beat.item.beep_type : pattern_ff;
   assign sel_pos = is_start ? 3'd0 : pos_next;
   assign lk_code = bps_pkg::rom_code(sel_pat, sel_pos);
   assign scaled  = 22'(master_volume) * 22'(bps_pkg::rom_vol_mul(sel_pat));
   assign lk_duty = (lk_code == bps_pkg::NOTE_PAUSE) ? 7'd0 : {1'b0, scaled[21:16]};

   // saturating time accumulate
   assign time_sum  = SUM_W'(time_ff) + SUM_W'(beat.item.elapsed_ms);
   assign tick_time = (time_sum > TMAX) ? TMAX[TIME_BITS-1:0] : time_sum[TIME_BITS-1:0];
   assign cur_dur   = TIME_BITS'(bps_pkg::rom_dur(pattern_ff, pos_ff));

   // next state per command
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      active_in    = active_ff;
      pattern_in   = pattern_ff;
      pos_in       = pos_ff;
      time_in      = time_ff;
      note_in      = note_ff;
      duty_in      = duty_ff;
      if (out_free) begin
         rsp_valid_in = take;
      end
      if (take) begin
         unique case (beat.item.command)
            bps_pkg::CMD_START: begin
               if (start_ok) begin
                  pattern_in = beat.item.beep_type;
                  pos_in     = 3'd0;
                  time_in    = '0;
                  active_in  = 1'b1;
                  note_in    = lk_code;
                  duty_in    = lk_duty;
               end
            end
            bps_pkg::CMD_STOP: begin
               active_in = 1'b0;
               pos_in    = 3'd0;
               time_in   = '0;
               note_in   = bps_pkg::NOTE_PAUSE;
               duty_in   = 7'd0;
            end
            bps_pkg::CMD_TICK: begin
               if (active_ff) begin
                  if (tick_time >= cur_dur) begin
                     time_in = '0;
                     if (pos_next == 3'd0 || pos_next >= bps_pkg::rom_count(pattern_ff)) begin
                        active_in = 1'b0;
                        pos_in    = 3'd0;
                        note_in   = bps_pkg::NOTE_PAUSE;
                        duty_in   = 7'd0;
                     end else begin
                        pos_in  = pos_next;
                        note_in = lk_code;
                        duty_in = lk_duty;
                     end
                  end else begin
                     time_in = tick_time;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         active_ff    <= 1'b0;
         pattern_ff   <= '0;
         pos_ff       <= '0;
         time_ff      <= '0;
         note_ff      <= bps_pkg::NOTE_PAUSE;
         duty_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         active_ff    <= active_in;
         pattern_ff   <= pattern_in;
         pos_ff       <= pos_in;
         time_ff      <= time_in;
         note_ff      <= note_in;
         duty_ff      <= duty_in;
      end
   end

   // result beat shows the state after its command
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_tone_note    = note_ff;
   assign rsp_duty_percent = duty_ff;
   assign rsp_playing      = active_ff;

   // checks
   `BPS_ASSERT_IMPLY(a_idle_silent, clock, reset, !active_ff, note_ff == bps_pkg::NOTE_PAUSE && duty_ff == 7'd0)
   `BPS_ASSERT_IMPLY(a_pos_in_range, clock, reset, active_ff, pos_ff < bps_pkg::rom_count(pattern_ff))
   `BPS_ASSERT_IMPLY(a_time_below_dur, clock, reset, active_ff, time_ff < cur_dur)
   `BPS_ASSERT_NEXT(a_stop_silences, clock, reset, take && beat.item.command == bps_pkg::CMD_STOP, !active_ff && duty_ff == 7'd0)

endmodule

[rtl/beep_pattern_sequencer.sv]
// Beep pattern sequencer: plays one of nine fixed buzzer patterns from rom.
// Request channel (req_valid / req_stall) carries one command beat: tick with
// elapsed ms, start of a pattern by number, or stop. Every request beat yields
// exactly one response beat (rsp_valid / rsp_stall) holding the note code,
// drive duty percent and playing flag as they stand after that command.
// csr_wr_en / csr_wr_data write the master volume percent, clamped to 100;
// a new volume applies from the next note start on.
// Path: a request beat accepted into the input register moves to the result
// register when the player takes it and is then shown as the response beat.
// Throughput: one beat per cycle while rsp_stall is low, set by the single pass
// through the rom lookup and the volume multiply between the two registers.
// Reset (synchronous, active high) empties both registers, silences the
// output, sets the master volume to 100 and leaves the player idle.
// A stalled response holds its payload; one more request beat is taken into
// the input register, after which req_stall rises until the result drains.
module beep_pattern_sequencer #(
   parameter int TIME_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [3:0]  req_beep_type,
   input  logic [15:0] req_elapsed_ms,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_tone_note,
   output logic [6:0]  rsp_duty_percent,
   output logic        rsp_playing,
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data
);

   logic                  take;
   logic [6:0]            master_volume;
   bps_pkg::req_beat_type beat;

   // master volume register
   bps_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .master_volume (master_volume)
   );

   // input register
   bps_req_stage u_req_stage (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_beep_type  (req_beep_type),
      .req_elapsed_ms (req_elapsed_ms),
      .take           (take),
      .beat           (beat)
   );

   // sequencer state and result register
   bps_player #(
      .TIME_BITS (TIME_BITS)
   ) u_player (
      .clock            (clock),
      .reset            (reset),
      .master_volume    (master_volume),
      .beat             (beat),
      .take             (take),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_tone_note    (rsp_tone_note),
      .rsp_duty_percent (rsp_duty_percent),
      .rsp_playing      (rsp_playing)
   );

endmodule

[bench/tb_beep_pattern_sequencer.sv]
module tb_beep_pattern_sequencer;

   // command code that the block must ignore
   localparam logic [1:0] CMD_SPARE = 2'd3;

   // short names for the note codes used in the song book
   localparam logic [2:0] N_PAUSE = bps_pkg::NOTE_PAUSE;
   localparam logic [2:0] N_DO    = bps_pkg::NOTE_DO;
   localparam logic [2:0] N_MI    = bps_pkg::NOTE_MI;
   localparam logic [2:0] N_SOL   = bps_pkg::NOTE_SOL;
   localparam logic [2:0] N_LA    = bps_pkg::NOTE_LA;
   localparam logic [2:0] N_HDO   = bps_pkg::NOTE_HDO;

   localparam int SONG_COUNT     = 9;
   localparam int ITEM_TOTAL     = 1950;
   localparam int CALM_TAIL      = 250;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int TIME_CAP       = 65535;

   typedef struct packed {
      logic [2:0] note;
      logic [6:0] duty;
      logic       playing;
   } tone_type;

   typedef struct packed {
      logic       vol_write;
      logic [6:0] vol;
      logic [1:0] command;
      logic [3:0] beep_type;
      logic [15:0] elapsed_ms;
      logic       known;
      tone_type   tone;
   } step_row;

   // song book: note codes, lengths in ms, note counts and volume per song
   localparam logic [2:0] SONG_NOTE [SONG_COUNT][7] = '{
      '{N_SOL, N_PAUSE, N_PAUSE, N_PAUSE, N_PAUSE, N_PAUSE, N_PAUSE},
      '{N_MI,  N_PAUSE, N_MI,    N_PAUSE, N_PAUSE, N_PAUSE, N_PAUSE},
      '{N_DO,  N_PAUSE, N_MI,    N_PAUSE, N_SOL,   N_PAUSE, N_PAUSE},
      '{N_DO,  N_PAUSE, N_MI,    N_PAUSE, N_SOL,   N_PAUSE, N_HDO},
      '{N_SOL, N_PAUSE, N_MI,    N_PAUSE, N_DO,    N_PAUSE, N_PAUSE},
      '{N_LA,  N_PAUSE, N_LA,    N_PAUSE, N_LA,    N_PAUSE, N_LA},
      '{N_DO,  N_PAUSE, N_SOL,   N_PAUSE, N_HDO,   N_PAUSE, N_PAUSE},
      '{N_HDO, N_PAUSE, N_PAUSE, N_PAUSE, N_PAUSE, N_PAUSE, N_PAUSE},
      '{N_SOL, N_PAUSE, N_HDO,   N_PAUSE, N_PAUSE, N_PAUSE, N_PAUSE}
   };
   localparam int SONG_MS [SONG_COUNT][7] = '{
      '{60,  0,  0,   0,   0,   0,  0},
      '{25,  50, 25,  0,   0,   0,  0},
      '{25,  50, 30,  50,  35,  0,  0},
      '{80,  30, 80,  30,  80,  30, 120},
      '{100, 50, 100, 50,  150, 0,  0},
      '{50,  30, 50,  100, 50,  30, 50},
      '{100, 50, 100, 50,  150, 0,  0},
      '{30,  0,  0,   0,   0,   0,  0},
      '{60,  40, 80,  0,   0,   0,  0}
   };
   localparam int SONG_LEN [SONG_COUNT] = '{1, 3, 5, 7, 5, 7, 5, 1, 3};
   localparam int SONG_VOL [SONG_COUNT] = '{20, 25, 30, 20, 25, 30, 20, 15, 20};

   localparam tone_type QUIET = '{N_PAUSE, 7'd0, 1'b0};

   // directed opening: corner cases first, typed expectations where obvious
   localparam int DIRECTED_ROWS = 28;
   localparam step_row DIRECTED [DIRECTED_ROWS] = '{
      '{1'b0, 7'd0,   bps_pkg::CMD_TICK,  4'd0,  16'hFFFF, 1'b1, QUIET},
      '{1'b0, 7'd0,   bps_pkg::CMD_STOP,  4'd0,  16'd0,    1'b1, QUIET},
      '{1'b0, 7'd0,   CMD_SPARE,          4'd15, 16'hFFFF, 1'b1, QUIET},
      '{1'b0, 7'd0,   bps_pkg::CMD_START, 4'd9,  16'd0,    1'b1, QUIET},
      '{1'b0, 7'd0,   bps_pkg::CMD_START, 4'd15, 16'hFFFF, 1'b1, QUIET},
      '{1'b0, 7'd0,   bps_pkg::CMD_START, 4'd0,  16'd0,    1'b1, '{N_SOL, 7'd20, 1'b1}},
      '{1'b0, 7'd0,   bps_pkg::CMD_TICK,  4'd0,  16'd59,   1'b0, QUIET},
      '{1'b0, 7'd0,   bps_pkg::CMD_TICK,  4'd0,  16'd1,    1'b1, QUIET},
      '{1'b0, 7'd0,   bps_pkg::CMD_START, 4'd3,  16'd0,    1'b1, '{N_DO, 7'd20, 1'b1}},
      '{1'b0, 7'd0,   bps_pkg::CMD_TICK,  4'd0,  16'hFFFF, 1'b0, QUIET},
      '{1'b0, 7'd0,   bps_pkg::CMD_TICK,  4'd0,  16'd0,    1'b0, QUIET},
      '{1'b0, 7'd0,   bps_pkg::CMD_START, 4'd7,  16'd0,    1'b1, '{N_HDO, 7'd15, 1'b1}},
      '{1'b0, 7'd0,   bps_pkg::CMD_STOP,  4'd0,  16'd0,    1'b1, QUIET},
      '{1'b1, 7'd0,   bps_pkg::CMD_TICK,  4'd0,  16'd0,    1'b0, QUIET},
      '{1'b0, 7'd0,   bps_pkg::CMD_START, 4'd5,  16'd0,    1'b1, '{N_LA, 7'd0, 1'b1}},
      '{1'b1, 7'd127, bps_pkg::CMD_TICK,  4'd0,  16'd0,    1'b0, QUIET},
      '{1'b0, 7'd0,   bps_pkg::CMD_TICK,  4'd0,  16'hFFFF, 1'b0, QUIET},
      '{1'b0, 7'd0,   bps_pkg::CMD_TICK,  4'd0,  16'hFFFF, 1'b0, QUIET},
      '{1'b1, 7'd1,   bps_pkg::CMD_TICK,  4'd0,  16'd0,    1'b0, QUIET},
      '{1'b0, 7'd0,   bps_pkg::CMD_START, 4'd2,  16'd0,    1'b1, '{N_DO, 7'd0, 1'b1}},
      '{1'b1, 7'd50,  bps_pkg::CMD_TICK,  4'd0,  16'd0,    1'b0, QUIET},
      '{1'b0, 7'd0,   bps_pkg::CMD_START, 4'd4,  16'd0,    1'b1, '{N_SOL, 7'd12, 1'b1}},
      '{1'b0, 7'd0,   bps_pkg::CMD_TICK,  4'd0,  16'd99,   1'b0, QUIET},
      '{1'b0, 7'd0,   bps_pkg::CMD_TICK,  4'd0,  16'hFFFF, 1'b0, QUIET},
      '{1'b0, 7'd0,   bps_pkg::CMD_START, 4'd8,  16'd0,    1'b0, QUIET},
      '{1'b0, 7'd0,   bps_pkg::CMD_TICK,  4'd0,  16'h5555, 1'b0, QUIET},
      '{1'b1, 7'd100, bps_pkg::CMD_TICK,  4'd0,  16'd0,    1'b0, QUIET},
      '{1'b0, 7'd0,   bps_pkg::CMD_START, 4'd6,  16'hAAAA, 1'b1, '{N_DO, 7'd20, 1'b1}}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_command = bps_pkg::CMD_TICK;
   logic [3:0]  req_beep_type = 4'd0;
   logic [15:0] req_elapsed_ms = 16'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_tone_note;
   logic [6:0]  rsp_duty_percent;
   logic        rsp_playing;
   logic        csr_wr_en = 1'b0;
   logic [6:0]  csr_wr_data = 7'd0;

   // player model state
   int          master_pct = 100;
   bit          song_on = 1'b0;
   int          song_sel = 0;
   int          note_idx = 0;
   int          ms_in_note = 0;
   logic [2:0]  out_note = N_PAUSE;
   logic [6:0]  out_duty = 7'd0;

   tone_type    tones_due [$];
   int unsigned fail_count = 0;
   int unsigned sent_beats = 0;
   int unsigned gap_odds = 0;
   int unsigned stall_odds = 0;
   int unsigned stall_left = 0;

   beep_pattern_sequencer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_beep_type    (req_beep_type),
      .req_elapsed_ms   (req_elapsed_ms),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_tone_note    (rsp_tone_note),
      .rsp_duty_percent (rsp_duty_percent),
      .rsp_playing      (rsp_playing),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   initial forever #2 clock = ~clock;

   // drive the current note of the selected song at the present volume
   function automatic void strike_note();
      int level;
      level = SONG_VOL[song_sel] * master_pct / 100;
      out_note = SONG_NOTE[song_sel][note_idx];
      out_duty = (out_note == N_PAUSE) ? 7'd0 : level[6:0];
   endfunction

   function automatic void hush();
      song_on = 1'b0;
      note_idx = 0;
      ms_in_note = 0;
      out_note = N_PAUSE;
      out_duty = 7'd0;
   endfunction

   // apply one command beat and report the tone that follows it
   function automatic void play_command(input bps_pkg::item_type cmd, output tone_type tone);
      int  sum;
      int  last;
      case (cmd.command)
         bps_pkg::CMD_START: begin
            if (cmd.beep_type < SONG_COUNT) begin
               song_sel = int'(cmd.beep_type);
               note_idx = 0;
               ms_in_note = 0;
               song_on = 1'b1;
               strike_note();
            end
         end
         bps_pkg::CMD_STOP: begin
            hush();
         end
         bps_pkg::CMD_TICK: begin
            if (song_on) begin
               sum = ms_in_note + int'(cmd.elapsed_ms);
               ms_in_note = (sum > TIME_CAP) ? TIME_CAP : sum;
               if (ms_in_note >= SONG_MS[song_sel][note_idx]) begin
                  note_idx++;
                  ms_in_note = 0;
                  last = (SONG_LEN[song_sel] > int'(bps_pkg::MAX_NOTES)) ?
                         int'(bps_pkg::MAX_NOTES) : SONG_LEN[song_sel];
                  if (note_idx >= last) hush();
                  else strike_note();
               end
            end
         end
         default: ;
      endcase
      tone.note = out_note;
      tone.duty = out_duty;
      tone.playing = song_on;
   endfunction

   // random beat: mostly songs started and ticked through, some noise
   function automatic bps_pkg::item_type pick_beat();
      bps_pkg::item_type cmd;
      int r;
      int span;
      r = $urandom_range(0, 99);
      cmd.beep_type = 4'($urandom_range(0, 15));
      cmd.elapsed_ms = 16'($urandom_range(0, 65535));
      if (!song_on) begin
         if (r < 75) cmd.command = bps_pkg::CMD_START;
         else if (r < 85) cmd.command = bps_pkg::CMD_START;
         else if (r < 92) cmd.command = bps_pkg::CMD_TICK;
         else if (r < 97) cmd.command = bps_pkg::CMD_STOP;
         else cmd.command = CMD_SPARE;
         if (r < 75) cmd.beep_type = 4'($urandom_range(0, SONG_COUNT - 1));
         else if (r < 85) cmd.beep_type = 4'($urandom_range(SONG_COUNT, 15));
      end else begin
         if (r < 80) cmd.command = bps_pkg::CMD_TICK;
         else if (r < 91) cmd.command = bps_pkg::CMD_START;
         else if (r < 96) cmd.command = bps_pkg::CMD_STOP;
         else cmd.command = CMD_SPARE;
         if (r >= 80 && r < 88) cmd.beep_type = 4'($urandom_range(0, SONG_COUNT - 1));
         if (r < 80) begin
            span = SONG_MS[song_sel][note_idx];
            case ($urandom_range(0, 19))
               0: cmd.elapsed_ms = 16'hFFFF;
               1: ;
               2: cmd.elapsed_ms = 16'd0;
               default: cmd.elapsed_ms = 16'($urandom_range(0, span + span / 4));
            endcase
         end
      end
      return cmd;
   endfunction

   // present one beat, hold it until taken, then book its expected tone
   task automatic send_beat(input bps_pkg::item_type cmd, input bit known,
                            input tone_type fixed);
      tone_type tone;
      req_valid <= 1'b1;
      req_command <= cmd.command;
      req_beep_type <= cmd.beep_type;
      req_elapsed_ms <= cmd.elapsed_ms;
      do @(posedge clock); while (req_stall !== 1'b0);
      play_command(cmd, tone);
      sent_beats++;
      tones_due.push_back(known ? fixed : tone);
   endtask

   task automatic hold_off(input int unsigned cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // volume write once the pipe has drained
   task automatic set_volume(input logic [6:0] pct);
      req_valid <= 1'b0;
      while (tones_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= pct;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      master_pct = int'((pct > bps_pkg::VOL_MAX) ? bps_pkg::VOL_MAX : pct);
   endtask

   function automatic logic [6:0] pick_volume();
      case ($urandom_range(0, 5))
         0: return 7'd0;
         1: return bps_pkg::VOL_MAX;
         2: return 7'd127;
         3: return 7'd101;
         default: return 7'($urandom_range(0, 127));
      endcase
   endfunction

   function automatic int unsigned pick_odds();
      case ($urandom_range(0, 2))
         0: return 0;
         1: return 12;
         default: return 3;
      endcase
   endfunction

   // receiver stall bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 1) begin
         stall_left <= stall_left - 1;
      end else if (stall_left == 1) begin
         stall_left <= 0;
         rsp_stall <= 1'b0;
      end else if (stall_odds != 0 && $urandom_range(0, stall_odds) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(1, 17);
      end
   end

   // response checker
   always @(posedge clock) begin
      tone_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (tones_due.size() == 0) begin
            if (fail_count < 10)
               $display("%0t: response beat with nothing expected: note %0d duty %0d playing %0d",
                        $time, rsp_tone_note, rsp_duty_percent, rsp_playing);
            fail_count++;
         end else begin
            want = tones_due.pop_front();
            if (rsp_tone_note !== want.note || rsp_duty_percent !== want.duty ||
                rsp_playing !== want.playing) begin
               if (fail_count < 10)
                  $display("%0t: expected note %0d duty %0d playing %0d, got %0d %0d %0d",
                           $time, want.note, want.duty, want.playing,
                           rsp_tone_note, rsp_duty_percent, rsp_playing);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles where no beat moves
   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("** beep_pattern_sequencer: FAILED **");
      $finish;
   end

   initial begin
      int unsigned row;
      int unsigned burst;
      int unsigned n;
      bps_pkg::item_type cmd;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows
      for (row = 0; row < DIRECTED_ROWS; row++) begin
         if (DIRECTED[row].vol_write) begin
            set_volume(DIRECTED[row].vol);
         end else begin
            cmd.command = DIRECTED[row].command;
            cmd.beep_type = DIRECTED[row].beep_type;
            cmd.elapsed_ms = DIRECTED[row].elapsed_ms;
            send_beat(cmd, DIRECTED[row].known, DIRECTED[row].tone);
         end
      end

      // random phases, each under a fresh volume and idling mix
      while (sent_beats < ITEM_TOTAL) begin
         if (sent_beats + CALM_TAIL >= ITEM_TOTAL) begin
            gap_odds = 0;
            stall_odds = 0;
         end else begin
            gap_odds = pick_odds();
            stall_odds = pick_odds();
         end
         set_volume(pick_volume());
         burst = $urandom_range(40, 120);
         for (n = 0; n < burst && sent_beats < ITEM_TOTAL; n++) begin
            send_beat(pick_beat(), 1'b0, QUIET);
            if (gap_odds != 0 && $urandom_range(0, gap_odds) == 0)
               hold_off($urandom_range(1, 17));
         end
      end

      // drain and let any stray beat show up
      req_valid <= 1'b0;
      while (tones_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("** beep_pattern_sequencer: PASSED **");
      end else begin
         $display("** beep_pattern_sequencer: FAILED **");
      end
      $finish;
   end

endmodule
